FILE: hw/rtl/fcma_pkg.sv
package fcma_pkg;

	localparam int NODE_COUNT = 64;
	localparam int VALUE_BITS = 32;
	localparam int DEPTH      = NODE_COUNT * NODE_COUNT;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int DELTA_W    = 33;
	localparam int SUM_W      = ((VALUE_BITS > DELTA_W) ? VALUE_BITS : DELTA_W) + 1;
	localparam int OUT_W      = 32;

	typedef enum logic [1:0] {
		MODE_ACC   = 2'd0,
		MODE_READ  = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_RMW,
		ST_CLEAR
	} state_t;

endpackage

FILE: hw/rtl/fem_conductance_matrix_assembly_unit.sv
// Accumulates element-matrix entries into a dense NODE_COUNT x NODE_COUNT
// global matrix held in one synchronous RAM. A request is taken when start is
// high and busy is low. Accumulate, read, bad-node and unused-mode requests
// pass through the read-modify-write state. The entry is read at the edge
// that takes the request. The saturated sum is written back at the end of the
// next cycle. Done pulses in the cycle after that with the result. Busy is
// high during the read-modify-write cycle, so a new request waits until it
// ends. A clear request walks all NODE_COUNT*NODE_COUNT entries (4096 at 64
// nodes), one entry per cycle, and its result follows the last write. After
// reset the same walk runs once, with busy high and no result, before the
// first request is taken. Results cannot be held off: sample them on done.
module fem_conductance_matrix_assembly_unit
	import fcma_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              mode,
	input  logic [6:0]              row_node,
	input  logic [6:0]              col_node,
	input  logic signed [31:0]      cond_value,
	input  logic signed [31:0]      deriv_value,
	output logic                    done,
	output logic signed [OUT_W-1:0] entry_value,
	output logic                    saturated,
	output logic                    index_error
);

	logic signed [VALUE_BITS-1:0] mem [DEPTH];

	state_t state_q, state_d;
	logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
	logic clr_last;

	logic accept;
	logic row_ok, col_ok;
	logic [31:0] idx_full;
	logic [IDX_W-1:0] idx_in;

	logic [1:0]                   mode_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic signed [DELTA_W-1:0]    delta_s1;
	logic                         ierr_s1;
	logic signed [VALUE_BITS-1:0] rd_q;

	logic signed [SUM_W-1:0]      sum;
	logic signed [SUM_W-1:0]      val_max_w, val_min_w;
	logic signed [VALUE_BITS-1:0] clip;
	logic                         clip_sat;
	logic signed [SUM_W-1:0]      clip_ext, rd_ext;

	logic                         mem_we;
	logic [IDX_W-1:0]             mem_waddr;
	logic signed [VALUE_BITS-1:0] mem_wdata;

	logic                    res_valid;
	logic signed [OUT_W-1:0] res_value;
	logic                    res_sat, res_ierr;

	logic                    done_q;
	logic signed [OUT_W-1:0] entry_q;
	logic                    sat_q, ierr_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign row_ok   = (row_node != 7'd0) && (32'(row_node) <= 32'(NODE_COUNT));
	assign col_ok   = (col_node != 7'd0) && (32'(col_node) <= 32'(NODE_COUNT));
	assign idx_full = (32'(row_node) - 32'd1) * 32'(NODE_COUNT) + (32'(col_node) - 32'd1);
	assign idx_in   = idx_full[IDX_W-1:0];

	assign clr_last = (32'(clr_cnt_q) == 32'(DEPTH - 1));

	// saturating add
	assign val_max_w = {{(SUM_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
	assign val_min_w = {{(SUM_W-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};
	assign sum       = SUM_W'(rd_q) + SUM_W'(delta_s1);

	always_comb begin
		clip_sat = 1'b0;
		clip     = sum[VALUE_BITS-1:0];
		if (sum > val_max_w) begin
			clip_sat = 1'b1;
			clip     = {1'b0, {(VALUE_BITS-1){1'b1}}};
		end else if (sum < val_min_w) begin
			clip_sat = 1'b1;
			clip     = {1'b1, {(VALUE_BITS-1){1'b0}}};
		end
	end

	assign clip_ext = SUM_W'(clip);
	assign rd_ext   = SUM_W'(rd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			clr_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			clr_cnt_q <= clr_cnt_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		clr_cnt_d = clr_cnt_q;
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = '0;
		res_valid = 1'b0;
		res_value = '0;
		res_sat   = 1'b0;
		res_ierr  = 1'b0;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				if (clr_last) begin
					clr_cnt_d = '0;
					state_d   = ST_IDLE;
				end else begin
					clr_cnt_d = clr_cnt_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (start) begin
					clr_cnt_d = '0;
					if (mode == MODE_CLEAR) begin
						state_d = ST_CLEAR;
					end else begin
						state_d = ST_RMW;
					end
				end
			end
			ST_RMW: begin
				res_valid = 1'b1;
				state_d   = ST_IDLE;
				if (ierr_s1) begin
					res_ierr = 1'b1;
				end else begin
					case (mode_s1)
						MODE_ACC: begin
							mem_we    = 1'b1;
							mem_wdata = clip;
							res_value = clip_ext[OUT_W-1:0];
							res_sat   = clip_sat;
						end
						MODE_READ: begin
							res_value = rd_ext[OUT_W-1:0];
						end
						default: begin
						end
					endcase
				end
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				if (clr_last) begin
					clr_cnt_d = '0;
					res_valid = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					clr_cnt_d = clr_cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode;
			idx_s1   <= idx_in;
			delta_s1 <= DELTA_W'(cond_value) + DELTA_W'(deriv_value);
			ierr_s1  <= ((mode == MODE_ACC) || (mode == MODE_READ)) && !(row_ok && col_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && row_ok && col_ok) begin
			rd_q <= mem[idx_in];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			entry_q <= res_value;
			sat_q   <= res_sat;
			ierr_q  <= res_ierr;
		end
	end

	assign done        = done_q;
	assign entry_value = entry_q;
	assign saturated   = sat_q;
	assign index_error = ierr_q;

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_RMW || (state_q == ST_CLEAR && clr_last)))
		else $error("result without finished request");

	a_accept_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode != MODE_CLEAR) |=> (state_q == ST_RMW))
		else $error("request not followed by read-modify-write");

	a_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == MODE_CLEAR) |=> (state_q == ST_CLEAR && clr_cnt_q == '0))
		else $error("clear request did not start walk");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(saturated && index_error))
		else $error("saturated and index error together");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != ST_IDLE))
		else $error("ram write while idle");

endmodule
